@@ rtl/core/interpolated_fir_mac_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the interpolated FIR MAC unit
// Immediate-style wrappers around concurrent assertions, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATED_FIR_MAC_UNIT_MACROS_SVH
`define INTERPOLATED_FIR_MAC_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define IFMU_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

`define IFMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define IFMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define IFMU_ASSERT(lbl, clk, rst_n, cond)

`define IFMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define IFMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/ifmu_pkg.sv @@
// ----------------------------------------------------------------------------
// ifmu_pkg
// Shared types and constants of the interpolated FIR MAC unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ifmu_pkg;

	localparam int PRECISION_DEF   = 31;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int NPHASE     = 4;
	localparam int NLANE      = 2 * NPHASE;
	localparam int LANE_IDX_W = $clog2(NLANE);
	localparam int PHASE_IDX_W = $clog2(NPHASE);
	localparam int CNT_W      = $clog2(NLANE + 1);

	localparam logic [1:0] MODE_FULL   = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_CUBIC  = 2'd2;

	typedef struct packed {
		logic [NPHASE-1:0][63:0] prod;
		logic [NPHASE-1:0][31:0] weight;
		logic                    last_tap;
	} q_entry_t;

	typedef enum logic [2:0] {
		B_RUN,
		B_MAC,
		B_DRAIN,
		B_ROUND,
		B_EMIT
	} back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/ifmu_ifs.sv @@
// ----------------------------------------------------------------------------
// ifmu_ifs
// Valid/ready channel interfaces: tap words in, result words out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifmu_tap_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic signed [31:0] coef0;
	logic signed [31:0] coef1;
	logic signed [31:0] coef2;
	logic signed [31:0] coef3;
	logic signed [31:0] weight0;
	logic signed [31:0] weight1;
	logic signed [31:0] weight2;
	logic signed [31:0] weight3;
	logic               last_tap;

	modport source (
		output valid, sample, coef0, coef1, coef2, coef3,
		output weight0, weight1, weight2, weight3, last_tap,
		input  ready
	);
	modport sink (
		input  valid, sample, coef0, coef1, coef2, coef3,
		input  weight0, weight1, weight2, weight3, last_tap,
		output ready
	);
endinterface

interface ifmu_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_sample;

	modport source (output valid, out_sample, input ready);
	modport sink (input valid, out_sample, output ready);
endinterface

interface ifmu_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] interp_mode;

	modport source (output valid, interp_mode, input ready);
	modport sink (input valid, interp_mode, output ready);
endinterface

`default_nettype wire

@@ rtl/core/interpolated_fir_mac_unit.sv @@
// Terms combined per result: N = 2 full, 4 linear, 8 cubic.
// Throughput: one non-final tap per cycle while the queue is not full, set by the lane accumulate in the back end.
// A final tap holds the back end in MAC, DRAIN, ROUND and EMIT: N lane terms, weighted except in full mode.
// The queue lets the front keep taking taps during that time until it fills.
// Reset: arst_n asynchronous, clears lanes, parity, queue, mode and valid flags.
// ----------------------------------------------------------------------------
// interpolated_fir_mac_unit
// Polyphase FIR inner product with full, linear and cubic phase combining.
// ----------------------------------------------------------------------------
`default_nettype none

module interpolated_fir_mac_unit
	import ifmu_pkg::*;
#(
	parameter int PRECISION   = PRECISION_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ifmu_tap_if.sink      taps,
	ifmu_result_if.source result,
	ifmu_cfg_if.sink      cfg
);

	logic       cfg_write;
	logic [1:0] interp_mode_q;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_valid;
	q_entry_t   q_din;
	q_entry_t   q_dout;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			interp_mode_q <= MODE_FULL;
		else if (cfg_write)
			interp_mode_q <= cfg.interp_mode;
	end

	ifmu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.taps   (taps),
		.q_push (q_push),
		.q_din  (q_din),
		.q_full (q_full)
	);

	ifmu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	ifmu_back #(
		.PRECISION (PRECISION)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_dout  (q_dout),
		.q_pop   (q_pop),
		.mode    (interp_mode_q),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ rtl/core/ifmu_queue.sv @@
// ----------------------------------------------------------------------------
// ifmu_queue
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmu_queue
	import ifmu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t din,
	output logic          full,
	input  wire logic     pop,
	output q_entry_t      dout,
	output logic          valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	q_entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W_Q'(DEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W_Q'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W_Q'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ifmu_front.sv @@
// ----------------------------------------------------------------------------
// ifmu_front
// Accept tap words, form the four phase products and queue them.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmu_front
	import ifmu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ifmu_tap_if.sink    taps,
	output logic        q_push,
	output q_entry_t    q_din,
	input  wire logic   q_full
);

	logic                     valid_s1;
	logic signed [31:0]       sample_s1;
	logic signed [31:0]       coef_s1 [NPHASE];
	logic [NPHASE-1:0][31:0]  weight_s1;
	logic                     last_s1;
	logic                     take;

	assign q_push     = valid_s1 && !q_full;
	assign taps.ready = !valid_s1 || !q_full;
	assign take       = taps.valid && taps.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (taps.ready)
			valid_s1 <= taps.valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1    <= taps.sample;
			coef_s1[0]   <= taps.coef0;
			coef_s1[1]   <= taps.coef1;
			coef_s1[2]   <= taps.coef2;
			coef_s1[3]   <= taps.coef3;
			weight_s1[0] <= taps.weight0;
			weight_s1[1] <= taps.weight1;
			weight_s1[2] <= taps.weight2;
			weight_s1[3] <= taps.weight3;
			last_s1      <= taps.last_tap;
		end
	end

	always_comb begin
		logic signed [63:0] p;
		q_din = '0;
		for (int i = 0; i < NPHASE; i++) begin
			p = sample_s1 * coef_s1[i];
			q_din.prod[i] = p;
		end
		q_din.weight   = weight_s1;
		q_din.last_tap = last_s1;
	end

endmodule

`default_nettype wire

@@ rtl/core/ifmu_back.sv @@
// ----------------------------------------------------------------------------
// ifmu_back
// Lane accumulation, combine (weighted except in full mode), round, saturate and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interpolated_fir_mac_unit_macros.svh"

module ifmu_back
	import ifmu_pkg::*;
#(
	parameter int PRECISION = PRECISION_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_valid,
	input  wire q_entry_t q_dout,
	output logic          q_pop,
	input  wire logic [1:0] mode,
	ifmu_result_if.source result
);

	localparam logic [63:0] RND = 64'd1 << (PRECISION - 1);

	back_state_t        state_q, state_d;
	logic [63:0]        lanes_q [NLANE];
	logic               parity_q;
	logic [31:0]        weights_q [NPHASE];
	logic [CNT_W-1:0]   cnt_q;
	logic [63:0]        term_q;
	logic               term_vld_q;
	logic [63:0]        total_q;
	logic signed [63:0] shifted_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	logic               issue;
	logic               load;
	logic [CNT_W-1:0]   nterm;
	logic [63:0]        term_d;
	logic [31:0]        sat_val;

	always_comb begin
		unique case (mode)
			MODE_FULL:   nterm = CNT_W'(2);
			MODE_LINEAR: nterm = CNT_W'(4);
			default:     nterm = CNT_W'(NLANE);
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_RUN:   if (q_valid && q_dout.last_tap) state_d = B_MAC;
			B_MAC:   if (cnt_q == nterm - CNT_W'(1)) state_d = B_DRAIN;
			B_DRAIN: state_d = B_ROUND;
			B_ROUND: state_d = B_EMIT;
			B_EMIT:  if (!out_valid_q || result.ready) state_d = B_RUN;
			default: state_d = B_RUN;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		issue = 1'b0;
		load  = 1'b0;
		unique case (state_q)
			B_RUN:   q_pop = q_valid;
			B_MAC:   issue = 1'b1;
			B_EMIT:  load  = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_comb begin
		logic [63:0]        lane;
		logic [63:0]        shl;
		logic signed [31:0] v;
		logic signed [31:0] w;
		logic signed [63:0] prod;
		lane = lanes_q[cnt_q[LANE_IDX_W-1:0]];
		shl  = lane >> PRECISION;
		v    = shl[31:0];
		w    = weights_q[cnt_q[LANE_IDX_W-1:1]];
		prod = v * w;
		if (mode == MODE_FULL)
			term_d = lane;
		else
			term_d = prod;
	end

	always_comb begin
		if (shifted_q[63:31] == {33{shifted_q[31]}})
			sat_val = shifted_q[31:0];
		else if (shifted_q[63])
			sat_val = 32'h8000_0000;
		else
			sat_val = 32'h7fff_ffff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			parity_q    <= 1'b0;
			cnt_q       <= '0;
			term_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NLANE; i++)
				lanes_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				for (int p = 0; p < NPHASE; p++)
					lanes_q[{PHASE_IDX_W'(p), parity_q}] <=
						lanes_q[{PHASE_IDX_W'(p), parity_q}] + q_dout.prod[p];
				parity_q <= !parity_q;
				cnt_q    <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			term_vld_q <= issue;
			if (load) begin
				for (int i = 0; i < NLANE; i++)
					lanes_q[i] <= '0;
				parity_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_dout.last_tap) begin
			for (int p = 0; p < NPHASE; p++)
				weights_q[p] <= q_dout.weight[p];
			total_q <= '0;
		end else if (term_vld_q) begin
			total_q <= total_q + term_q;
		end
		if (issue)
			term_q <= term_d;
		if (state_q == B_ROUND)
			shifted_q <= $signed(total_q + RND) >>> PRECISION;
		if (load)
			out_data_q <= sat_val;
	end

	assign result.valid      = out_valid_q;
	assign result.out_sample = out_data_q;

	`IFMU_ASSERT_IMPL(a_load_slot_free, clk, arst_n, load, !out_valid_q || result.ready)
	`IFMU_ASSERT_IMPL(a_pop_only_run, clk, arst_n, q_pop, state_q == B_RUN)
	`IFMU_ASSERT_IMPL(a_cnt_bound, clk, arst_n, state_q == B_MAC, cnt_q < nterm)
	`IFMU_ASSERT_NEXT(a_clear_after_load, clk, arst_n, load,
		lanes_q[0] == '0 && lanes_q[NLANE-1] == '0 && !parity_q)

endmodule

`default_nettype wire
